// ===== sv/pcf_pkg.sv =====
// Shared widths, constants and a helper function for the pair contact force block.
package pcf_pkg;

    localparam int POS_W      = 24;
    localparam int SIZE_W     = 8;
    localparam int SCALE_W    = 24;
    localparam int GAIN_W     = 16;
    localparam int FORCE_W    = 32;
    localparam int DIFF_W     = POS_W + 1;
    localparam int GS_W       = GAIN_W + SCALE_W;
    localparam int GS_SPLIT   = GS_W / 2;
    localparam int QUOT_W     = FORCE_W;
    localparam int NUM_W      = FORCE_W + DIFF_W;

    localparam logic [GAIN_W-1:0]  GAIN_RST  = 16'd256;
    localparam logic [FORCE_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [FORCE_W-1:0] NEG_LIMIT = 32'h8000_0000;

    // Clamps an unsigned quotient into the signed output range and applies the sign.
    function automatic logic [FORCE_W-1:0] apply_sign(input logic [QUOT_W-1:0] q,
                                                      input logic neg);
        logic [FORCE_W-1:0] mag;
        begin
            if (neg) begin
                mag = (q > NEG_LIMIT) ? NEG_LIMIT : q;
                apply_sign = ~mag + FORCE_W'(1);
            end else begin
                apply_sign = (q > POS_LIMIT) ? POS_LIMIT : q;
            end
        end
    endfunction

endpackage

// ===== sv/pair_contact_force.sv =====
// Top level of the pair contact force pipeline.
//
// Takes one disc pair per cycle while the output is not stalled and returns the
// repulsive force on the first disc, its magnitude and the contact flag. Registers
// hold the differences, squares and contact test, the pipelined square root over
// POS_FRAC_BITS + 8 root bits, the overlap and force magnitude products, the quotient
// bits of the two 32-bit direction dividers, and the output register. A result that
// is not taken stalls the whole pipeline; nothing is lost or repeated. The contact
// gain must only be written while no pair is in flight.
module pair_contact_force
    import pcf_pkg::*;
#(
    parameter int POS_FRAC_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [GAIN_W-1:0]         i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [POS_W-1:0]   i_first_x,
    input  logic signed [POS_W-1:0]   i_first_y,
    input  logic signed [POS_W-1:0]   i_second_x,
    input  logic signed [POS_W-1:0]   i_second_y,
    input  logic [SIZE_W-1:0]         i_first_size,
    input  logic [SIZE_W-1:0]         i_second_size,
    input  logic [SCALE_W-1:0]        i_accel_scale,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [FORCE_W-1:0] o_force_x,
    output logic signed [FORCE_W-1:0] o_force_y,
    output logic [FORCE_W-1:0]        o_force_mag,
    output logic                      o_in_contact
);

    localparam int RW     = POS_FRAC_BITS + SIZE_W;
    localparam int SW     = 2 * RW;
    localparam int PW     = GS_W + RW;
    localparam int MAG_SH = 16 + POS_FRAC_BITS;
    localparam int LAT    = RW + 40;

    typedef struct packed {
        logic              sx;
        logic              sy;
        logic [DIFF_W-1:0] ax;
        logic [DIFF_W-1:0] ay;
        logic [RW-1:0]     rsum;
        logic [GS_W-1:0]   gs;
        logic              contact;
    } t_front_side;

    typedef struct packed {
        logic              sx;
        logic              sy;
        logic [RW-1:0]     dlen;
        logic [FORCE_W-1:0] mag;
        logic              contact;
    } t_div_side;

    logic              en;
    logic [LAT-1:0]    r_vld;
    logic [GAIN_W-1:0] r_gain;

    assign en         = ~r_vld[LAT-1] | i_out_ready;
    assign o_in_ready = en;
    assign o_out_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_gain <= GAIN_RST;
        end else begin
            if (en) begin
                r_vld <= {r_vld[LAT-2:0], i_in_valid};
            end
            if (i_cfg_we) begin
                r_gain <= i_cfg_data;
            end
        end
    end

    // Stage A: differences, their magnitudes and the radius sum.
    logic signed [DIFF_W-1:0] n_dx, n_dy;
    logic [SIZE_W:0]          n_size_sum;
    logic [DIFF_W-1:0]        r_a_ax, r_a_ay;
    logic                     r_a_sx, r_a_sy;
    logic [RW-1:0]            r_a_rsum;
    logic [SCALE_W-1:0]       r_a_scale;

    assign n_dx = {i_first_x[POS_W-1], i_first_x} - {i_second_x[POS_W-1], i_second_x};
    assign n_dy = {i_first_y[POS_W-1], i_first_y} - {i_second_y[POS_W-1], i_second_y};
    assign n_size_sum = {1'b0, i_first_size} + {1'b0, i_second_size};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_sx    <= n_dx[DIFF_W-1];
            r_a_sy    <= n_dy[DIFF_W-1];
            r_a_ax    <= n_dx[DIFF_W-1] ? (~n_dx + DIFF_W'(1)) : n_dx;
            r_a_ay    <= n_dy[DIFF_W-1] ? (~n_dy + DIFF_W'(1)) : n_dy;
            r_a_rsum  <= RW'(n_size_sum) << (POS_FRAC_BITS - 1);
            r_a_scale <= i_accel_scale;
        end
    end

    // Stage B: squares and the gain-scale product.
    logic [2*DIFF_W-1:0] r_b_sqx, r_b_sqy;
    logic [SW-1:0]       r_b_rs2;
    t_front_side         r_b_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_sqx          <= r_a_ax * r_a_ax;
            r_b_sqy          <= r_a_ay * r_a_ay;
            r_b_rs2          <= r_a_rsum * r_a_rsum;
            r_b_side.sx      <= r_a_sx;
            r_b_side.sy      <= r_a_sy;
            r_b_side.ax      <= r_a_ax;
            r_b_side.ay      <= r_a_ay;
            r_b_side.rsum    <= r_a_rsum;
            r_b_side.gs      <= r_gain * r_a_scale;
            r_b_side.contact <= 1'b0;
        end
    end

    // Stage C: squared distance and the exact contact test; feeds the root pipeline.
    logic [2*DIFF_W:0] n_d2;
    logic              n_contact;
    t_front_side       n_sq_side;
    logic [SW-1:0]     r_sq_rem  [0:RW];
    logic [RW-1:0]     r_sq_root [0:RW];
    t_front_side       r_sq_side [0:RW];

    assign n_d2      = {1'b0, r_b_sqx} + {1'b0, r_b_sqy};
    assign n_contact = n_d2 < (2*DIFF_W+1)'(r_b_rs2);

    always_comb begin
        n_sq_side         = r_b_side;
        n_sq_side.contact = n_contact;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_rem[0]  <= n_contact ? n_d2[SW-1:0] : '0;
            r_sq_root[0] <= '0;
            r_sq_side[0] <= n_sq_side;
        end
    end

    // One root bit per stage, most significant first.
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int I = RW - 1 - k;
        logic [SW:0] w_trial;
        logic        w_take;

        assign w_trial = ((SW+1)'(r_sq_root[k]) << (I + 1)) + ((SW+1)'(1) << (2 * I));
        assign w_take  = {1'b0, r_sq_rem[k]} >= w_trial;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq_rem[k+1]  <= w_take ? (r_sq_rem[k] - w_trial[SW-1:0]) : r_sq_rem[k];
                r_sq_root[k+1] <= w_take ? (r_sq_root[k] | (RW'(1) << I)) : r_sq_root[k];
                r_sq_side[k+1] <= r_sq_side[k];
            end
        end
    end

    // Overlap, force magnitude and the divider numerators.
    logic [RW-1:0]            r_m1_ov, r_m1_dist;
    t_front_side              r_m1_side;
    logic [GS_SPLIT+RW-1:0]   r_m2_plo;
    logic [GS_W-GS_SPLIT+RW-1:0] r_m2_phi;
    logic [RW-1:0]            r_m2_dist;
    t_front_side              r_m2_side;
    logic [PW-1:0]            n_prod;
    t_div_side                r_m3_side;
    logic [DIFF_W-1:0]        r_m3_ax, r_m3_ay;

    assign n_prod = PW'(r_m2_plo) + (PW'(r_m2_phi) << GS_SPLIT);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m1_ov   <= r_sq_side[RW].rsum - r_sq_root[RW];
            r_m1_dist <= r_sq_root[RW];
            r_m1_side <= r_sq_side[RW];

            r_m2_plo  <= r_m1_side.gs[GS_SPLIT-1:0] * r_m1_ov;
            r_m2_phi  <= r_m1_side.gs[GS_W-1:GS_SPLIT] * r_m1_ov;
            r_m2_dist <= r_m1_dist;
            r_m2_side <= r_m1_side;

            // The product never reaches 2^(MAG_SH+32), so no clamp is needed here.
            r_m3_side.mag     <= r_m2_side.contact ? n_prod[MAG_SH +: FORCE_W] : '0;
            r_m3_side.dlen    <= r_m2_dist;
            r_m3_side.sx      <= r_m2_side.sx;
            r_m3_side.sy      <= r_m2_side.sy;
            r_m3_side.contact <= r_m2_side.contact;
            r_m3_ax           <= r_m2_side.ax;
            r_m3_ay           <= r_m2_side.ay;
        end
    end

    logic [NUM_W-1:0]  r_dv_remx [0:QUOT_W];
    logic [NUM_W-1:0]  r_dv_remy [0:QUOT_W];
    logic [QUOT_W-1:0] r_dv_qx   [0:QUOT_W];
    logic [QUOT_W-1:0] r_dv_qy   [0:QUOT_W];
    t_div_side         r_dv_side [0:QUOT_W];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_remx[0] <= r_m3_side.mag * r_m3_ax;
            r_dv_remy[0] <= r_m3_side.mag * r_m3_ay;
            r_dv_qx[0]   <= '0;
            r_dv_qy[0]   <= '0;
            r_dv_side[0] <= r_m3_side;
        end
    end

    // One quotient bit per stage. Each component is at most the distance, so the
    // quotient never exceeds the magnitude and fits in 32 bits.
    for (genvar k = 0; k < QUOT_W; k++) begin : g_div
        localparam int I = QUOT_W - 1 - k;
        logic [NUM_W-1:0] w_sub;
        logic             w_take_x, w_take_y;

        assign w_sub    = NUM_W'(r_dv_side[k].dlen) << I;
        assign w_take_x = r_dv_remx[k] >= w_sub;
        assign w_take_y = r_dv_remy[k] >= w_sub;

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_remx[k+1] <= w_take_x ? (r_dv_remx[k] - w_sub) : r_dv_remx[k];
                r_dv_remy[k+1] <= w_take_y ? (r_dv_remy[k] - w_sub) : r_dv_remy[k];
                r_dv_qx[k+1]   <= w_take_x ? (r_dv_qx[k] | (QUOT_W'(1) << I)) : r_dv_qx[k];
                r_dv_qy[k+1]   <= w_take_y ? (r_dv_qy[k] | (QUOT_W'(1) << I)) : r_dv_qy[k];
                r_dv_side[k+1] <= r_dv_side[k];
            end
        end
    end

    // Output register; coincident discs have no direction.
    logic n_no_dir;
    logic [FORCE_W-1:0] r_out_fx, r_out_fy, r_out_mag;
    logic               r_out_contact;

    assign n_no_dir = (r_dv_side[QUOT_W].dlen == '0);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_fx      <= n_no_dir ? '0 : apply_sign(r_dv_qx[QUOT_W], r_dv_side[QUOT_W].sx);
            r_out_fy      <= n_no_dir ? '0 : apply_sign(r_dv_qy[QUOT_W], r_dv_side[QUOT_W].sy);
            r_out_mag     <= r_dv_side[QUOT_W].mag;
            r_out_contact <= r_dv_side[QUOT_W].contact;
        end
    end

    assign o_force_x    = r_out_fx;
    assign o_force_y    = r_out_fy;
    assign o_force_mag  = r_out_mag;
    assign o_in_contact = r_out_contact;

`ifndef SYNTHESIS
    a_no_contact_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_contact |-> o_force_mag == '0 && o_force_x == '0 && o_force_y == '0)
        else $error("force without contact");

    a_zero_mag_zero_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_force_mag == '0 |-> o_force_x == '0 && o_force_y == '0)
        else $error("direction force with zero magnitude");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input taken while output stalled");
`endif

endmodule
